[sv/multitone_sine_generator_defines.svh]
`ifndef MULTITONE_SINE_GENERATOR_DEFINES_SVH
`define MULTITONE_SINE_GENERATOR_DEFINES_SVH

// expects clk and rst in scope
`define MTSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`define MTSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// checked through reset as well
`define MTSG_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mtsg_pkg.sv]
`timescale 1ns / 1ps

package mtsg_pkg;

  localparam int unsigned STEP_REGS = 4;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned ACC_W     = 18;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam logic [2:0]  TONE_COUNT_RST   = 3'd1;
  localparam logic [31:0] STEP_ZERO_RST    = 32'd42852281;
  localparam logic [15:0] VOLUME_RST       = 16'd22938;
  localparam logic [23:0] SAMPLE_COUNT_RST = 24'd44100;
  localparam logic [15:0] VOL_ONE          = 16'd32768;
  localparam logic [14:0] PCM_MAX          = 15'h7fff;
  localparam logic [39:0] DIV3_MUL         = 40'd349526;

  typedef logic signed [15:0] sample_t;

  typedef enum logic [2:0] {
    REG_TONE_COUNT   = 3'd0,
    REG_STEP_ZERO    = 3'd1,
    REG_STEP_ONE     = 3'd2,
    REG_STEP_TWO     = 3'd3,
    REG_STEP_THREE   = 3'd4,
    REG_VOLUME       = 3'd5,
    REG_SAMPLE_COUNT = 3'd6
  } reg_index_t;

  // quarter-wave entry, q30 taylor series of degree 11, evaluated at elaboration
  function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x    = (64'(PI_Q30) * 64'(2 * k + 1)) >> (bits + 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - signed'(term);
    if (acc < 0) begin
      acc = '0;
    end
    v = ((64'(acc) * 64'd32767) + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

[sv/multitone_sine_generator.sv]
`timescale 1ns / 1ps

// channel  dir  handshake           payload
// in       in   in_valid/in_ready   restart
// out      out  out_valid/out_ready sample, last
// cfg      in   cfg_write           cfg_index, cfg_data
//
// one beat in is worked through in full before the next acceptance;
// the phase memory and sine rom are visited once per tone, one tone a cycle,
// then scaling arithmetic in mul, scale, abs, div; state out loads the output register.
// synchronous reset restores config, zeroes index and live flags, so phases read zero.
// a finished beat waits in the output register; the next input beat is taken meanwhile.

module multitone_sine_generator
  import mtsg_pkg::*;
#(
  parameter int MAX_TONES       = 4,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             restart,
  output logic             out_valid,
  input  logic             out_ready,
  output sample_t          sample,
  output logic             last,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int TW    = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int TAB_N = 1 << SINE_TABLE_BITS;
  localparam int NMAX  = (MAX_TONES < STEP_REGS) ? MAX_TONES : STEP_REGS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TONES = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_SCALE = 7'b0001000,
    S_ABS   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [2:0]          tone_count;
  logic [31:0]         step_reg [STEP_REGS];
  logic [15:0]         volume;
  logic [COUNT_W-1:0]  sample_count;

  logic [INDEX_BITS-1:0] sample_index;
  logic [31:0]           phase_mem [MAX_TONES];
  logic [MAX_TONES-1:0]  live;

  logic [14:0] sine_rom [TAB_N];

  logic [2:0]            tc_lo;
  logic [2:0]            n_eff;
  logic [15:0]           vol_eff;
  logic [COUNT_W-1:0]    cnt_eff;
  logic [INDEX_BITS-1:0] idx_start;
  logic                  is_last;
  logic                  accept;
  logic                  done;
  logic                  out_free;

  logic [TW-1:0] rd_tone;
  logic          issuing;
  logic [31:0]   rd_q;
  logic          rd_live;
  logic [TW-1:0] t1;
  logic          v1;
  logic [2:0]    t1_ext;
  logic [31:0]   ph1;
  logic [31:0]   step_sel;
  logic [SINE_TABLE_BITS-1:0] k_raw;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic [14:0]   sine_q;
  logic          neg2;
  logic          v2;
  logic signed [ACC_W-1:0] sine_signed;
  logic signed [ACC_W-1:0] acc;
  logic          last_flag;

  logic signed [34:0] prod;
  logic signed [49:0] scaled;
  logic [49:0]        mag;
  logic [19:0]        xq;
  logic               neg_s;
  logic [39:0]        div3_prod;
  logic [19:0]        quot;
  logic [14:0]        sat;
  sample_t            val;

  for (genvar g = 0; g < TAB_N; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_count   <= TONE_COUNT_RST;
      step_reg[0]  <= STEP_ZERO_RST;
      step_reg[1]  <= '0;
      step_reg[2]  <= '0;
      step_reg[3]  <= '0;
      volume       <= VOLUME_RST;
      sample_count <= SAMPLE_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TONE_COUNT:   tone_count   <= cfg_data[2:0];
        REG_STEP_ZERO:    step_reg[0]  <= cfg_data;
        REG_STEP_ONE:     step_reg[1]  <= cfg_data;
        REG_STEP_TWO:     step_reg[2]  <= cfg_data;
        REG_STEP_THREE:   step_reg[3]  <= cfg_data;
        REG_VOLUME:       volume       <= cfg_data[15:0];
        REG_SAMPLE_COUNT: sample_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tc_lo     = (tone_count == 3'd0) ? 3'd1 : tone_count;
    n_eff     = (tc_lo > 3'(NMAX)) ? 3'(NMAX) : tc_lo;
    vol_eff   = (volume > VOL_ONE) ? VOL_ONE : volume;
    cnt_eff   = (sample_count == '0) ? COUNT_W'(1) : sample_count;
    idx_start = restart ? '0 : sample_index;
    is_last   = 33'(idx_start) >= (33'(cnt_eff) - 33'd1);
    in_ready  = (state == S_IDLE);
    accept    = in_valid && in_ready;
    done      = !issuing && !v1 && !v2;
    out_free  = !out_valid || out_ready;

    t1_ext   = 3'(t1);
    step_sel = step_reg[t1_ext[1:0]];
    ph1      = rd_live ? rd_q : '0;
    k_raw    = ph1[29 -: SINE_TABLE_BITS];
    rom_addr = ph1[30] ? ~k_raw : k_raw;

    sine_signed = neg2 ? -$signed({3'b000, sine_q}) : $signed({3'b000, sine_q});

    mag       = scaled[49] ? 50'(-scaled) : 50'(scaled);
    div3_prod = 40'(xq) * DIV3_MUL;
    sat       = (quot > 20'(PCM_MAX)) ? PCM_MAX : quot[14:0];
    val       = neg_s ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  end

  // phase store: read one tone a cycle, write the advanced phase back in the cycle after its read
  always_ff @(posedge clk) begin
    rd_q <= phase_mem[rd_tone];
    if (v1) begin
      phase_mem[t1] <= ph1 + step_sel;
    end
  end

  always_ff @(posedge clk) begin
    rd_live <= live[rd_tone];
    t1      <= rd_tone;
    sine_q  <= sine_rom[rom_addr];
    neg2    <= ph1[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_index <= '0;
      live         <= '0;
      issuing      <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      rd_tone      <= '0;
      out_valid    <= 1'b0;
    end else begin
      v1 <= (state == S_TONES) && issuing;
      v2 <= v1;

      if (accept && restart) begin
        live <= '0;
      end else if ((state == S_TONES) && done && last_flag) begin
        live <= '0;
      end else if (v1) begin
        live[t1] <= 1'b1;
      end

      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            sample_index <= is_last ? '0 : idx_start + INDEX_BITS'(1);
            rd_tone      <= '0;
            issuing      <= 1'b1;
            state        <= S_TONES;
          end
        end
        S_TONES: begin
          if (issuing) begin
            rd_tone <= rd_tone + TW'(1);
            if (3'(rd_tone) == (n_eff - 3'd1)) begin
              issuing <= 1'b0;
            end
          end
          if (done) begin
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_SCALE;
        S_SCALE: state <= S_ABS;
        S_ABS:   state <= S_DIV;
        S_DIV:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // mixing datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      acc       <= '0;
      last_flag <= is_last;
    end else if (v2) begin
      acc <= acc + sine_signed;
    end

    if (state == S_MUL) begin
      prod <= acc * $signed({1'b0, vol_eff});
    end
    if (state == S_SCALE) begin
      scaled <= (50'(prod) <<< 15) - 50'(prod);
    end
    if (state == S_ABS) begin
      xq    <= mag[49:30];
      neg_s <= scaled[49];
    end
    if (state == S_DIV) begin
      case (n_eff)
        3'd2:    quot <= xq >> 1;
        3'd3:    quot <= div3_prod[39:20];
        3'd4:    quot <= xq >> 2;
        default: quot <= xq;
      endcase
    end
    if ((state == S_OUT) && out_free) begin
      sample <= val;
      last   <= last_flag;
    end
  end

endmodule

[sv/mtsg_checker.sv]
`timescale 1ns / 1ps

`include "multitone_sine_generator_defines.svh"

module mtsg_checker
  import mtsg_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t sample,
  input logic    last
);

  `MTSG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped")
  `MTSG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(sample) && $stable(last), "stalled output beat changed")
  `MTSG_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second input beat taken while busy")
  `MTSG_ASSERT_NOW(a_sample_range, out_valid, sample != 16'sh8000, "sample outside clamp range")
  `MTSG_ASSERT_RST(a_reset_empty, rst, !out_valid, "output valid after reset")

endmodule

bind multitone_sine_generator mtsg_checker u_mtsg_checker (.*);
